// ===== src/card_key_derivation_mixer_core_macros.svh =====
// assertion macros for the card key derivation mixer checker
// no dependencies; taken in by the checker file
`ifndef CARD_KEY_DERIVATION_MIXER_CORE_MACROS_SVH
`define CARD_KEY_DERIVATION_MIXER_CORE_MACROS_SVH

// property sampled on the rising clock, off while reset is low
`define CKDM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// a signal holds its value across a cycle in which cond is true
`define CKDM_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
  `CKDM_ASSERT(label, clk, rst_n, (cond) |=> $stable(sig), msg)

`endif

// ===== src/ckdm_pkg.sv =====
// shared types and constants of the card key derivation mixer
// the round table of the byte mixing function; no dependencies
package ckdm_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned NumBytes  = 4;
  localparam int unsigned WordW     = ByteW * NumBytes;
  localparam int unsigned NumRounds = 8;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [1:0]       byte_idx_t;

  typedef struct packed {
    byte_idx_t a;
    byte_idx_t b;
    byte_idx_t p;
    byte_idx_t q;
    byte_idx_t ca;
    byte_idx_t cb;
    byte_idx_t dst;
  } mix_round_t;

  localparam mix_round_t MixRounds [NumRounds] = '{
    '{a: 2'd2, b: 2'd3, p: 2'd0, q: 2'd1, ca: 2'd0, cb: 2'd1, dst: 2'd0},
    '{a: 2'd0, b: 2'd1, p: 2'd1, q: 2'd2, ca: 2'd2, cb: 2'd3, dst: 2'd2},
    '{a: 2'd1, b: 2'd0, p: 2'd2, q: 2'd3, ca: 2'd3, cb: 2'd2, dst: 2'd2},
    '{a: 2'd2, b: 2'd3, p: 2'd0, q: 2'd3, ca: 2'd1, cb: 2'd0, dst: 2'd0},
    '{a: 2'd3, b: 2'd2, p: 2'd0, q: 2'd3, ca: 2'd1, cb: 2'd0, dst: 2'd0},
    '{a: 2'd0, b: 2'd1, p: 2'd2, q: 2'd3, ca: 2'd3, cb: 2'd2, dst: 2'd2},
    '{a: 2'd1, b: 2'd0, p: 2'd1, q: 2'd2, ca: 2'd3, cb: 2'd2, dst: 2'd2},
    '{a: 2'd2, b: 2'd3, p: 2'd0, q: 2'd1, ca: 2'd1, cb: 2'd0, dst: 2'd0}
  };

endpackage

// ===== src/ckdm_if.sv =====
// valid/ready channels of the card key derivation mixer
// depends on ckdm_pkg for the word type
interface ckdm_text_if;
  logic            valid;
  logic            ready;
  ckdm_pkg::word_t card_text;

  modport source (output valid, output card_text, input ready);
  modport sink   (input valid, input card_text, output ready);
endinterface

interface ckdm_key_if;
  logic            valid;
  logic            ready;
  ckdm_pkg::word_t key_plain_half;
  ckdm_pkg::word_t key_inverted_half;

  modport source (output valid, output key_plain_half, output key_inverted_half,
                  input ready);
  modport sink   (input valid, input key_plain_half, input key_inverted_half,
                  output ready);
endinterface

interface ckdm_cfg_if;
  logic            valid;
  logic            ready;
  ckdm_pkg::word_t work_key;

  modport source (output valid, output work_key, input ready);
  modport sink   (input valid, input work_key, output ready);
endinterface

// ===== src/ckdm_mix.sv =====
// eight-round byte mixing of one 32-bit word under the work key
// depends on ckdm_pkg for the round table
module ckdm_mix (
  input  ckdm_pkg::word_t work_key_i,
  input  ckdm_pkg::word_t data_i,
  output ckdm_pkg::word_t mixed_o
);

  always_comb begin
    ckdm_pkg::byte_t    k [ckdm_pkg::NumBytes];
    ckdm_pkg::byte_t    y [ckdm_pkg::NumBytes];
    ckdm_pkg::byte_t    kx;
    ckdm_pkg::byte_t    ks;
    ckdm_pkg::byte_t    m;
    ckdm_pkg::byte_t    n;
    ckdm_pkg::mix_round_t r;
    for (int i = 0; i < ckdm_pkg::NumBytes; i++) begin
      k[i] = work_key_i[i*ckdm_pkg::ByteW +: ckdm_pkg::ByteW];
      y[i] = data_i[i*ckdm_pkg::ByteW +: ckdm_pkg::ByteW];
    end
    for (int j = 0; j < ckdm_pkg::NumRounds; j++) begin
      r  = ckdm_pkg::MixRounds[j];
      kx = k[r.p] ^ k[r.q];
      ks = k[r.p] + k[r.q];
      m  = (y[r.a] + kx) ^ y[r.ca];
      n  = (ks + y[r.b]) ^ y[r.cb];
      y[r.dst]        = m;
      y[r.dst + 2'd1] = n;
    end
    for (int i = 0; i < ckdm_pkg::NumBytes; i++) begin
      mixed_o[i*ckdm_pkg::ByteW +: ckdm_pkg::ByteW] = y[i];
    end
  end

endmodule

// ===== src/card_key_derivation_mixer_core.sv =====
// top level of the card key derivation mixer: input and result registers
// depends on ckdm_pkg, ckdm_if and ckdm_mix
//
//   channel  | dir | payload                              | transfer
//   cfg_if   | in  | work_key                             | valid & ready
//   text_if  | in  | card_text                            | valid & ready
//   key_if   | out | key_plain_half, key_inverted_half    | valid & ready
//
// one item per cycle while the result is not stalled; a transfer in passes through
// the text register and then the result register before its result is offered
// the mixing network sits between the text register and the result register
// reset clears both valid flags and the work key
// a stalled result holds; one more item can wait in the text register
// cfg_if is always ready
module card_key_derivation_mixer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ckdm_cfg_if.sink   cfg_if,
  ckdm_text_if.sink  text_if,
  ckdm_key_if.source key_if
);

  ckdm_pkg::word_t work_key_q;
  ckdm_pkg::word_t text_q;
  logic            text_valid_q;
  ckdm_pkg::word_t plain_q;
  ckdm_pkg::word_t inverted_q;
  logic            key_valid_q;
  ckdm_pkg::word_t plain_mix;
  ckdm_pkg::word_t inverted_mix;
  logic            key_load;
  logic            text_load;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_key_q <= '0;
    end else if (cfg_if.valid) begin
      work_key_q <= cfg_if.work_key;
    end
  end

  assign key_load      = text_valid_q && (!key_valid_q || key_if.ready);
  assign text_load     = text_if.valid && text_if.ready;
  assign text_if.ready = !text_valid_q || !key_valid_q || key_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_valid_q <= 1'b0;
    end else if (text_if.ready) begin
      text_valid_q <= text_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_load) begin
      text_q <= text_if.card_text;
    end
  end

  ckdm_mix u_mix_plain (
    .work_key_i (work_key_q),
    .data_i     (text_q),
    .mixed_o    (plain_mix)
  );

  ckdm_mix u_mix_inverted (
    .work_key_i (work_key_q),
    .data_i     (~text_q),
    .mixed_o    (inverted_mix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_valid_q <= 1'b0;
    end else if (!key_valid_q || key_if.ready) begin
      key_valid_q <= text_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_load) begin
      plain_q    <= plain_mix;
      inverted_q <= inverted_mix;
    end
  end

  assign key_if.valid             = key_valid_q;
  assign key_if.key_plain_half    = plain_q;
  assign key_if.key_inverted_half = inverted_q;

endmodule

// ===== src/ckdm_checker.sv =====
// port checker of the card key derivation mixer and its bind
// depends on ckdm_pkg, the macro header and the top level's ports
`include "card_key_derivation_mixer_core_macros.svh"

module ckdm_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input ckdm_pkg::word_t out_plain_i
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  `CKDM_ASSERT(a_out_valid_holds, clk_i, rst_ni, out_stall |=> out_valid_i, "result dropped")
  `CKDM_ASSERT_HOLD(a_out_data_holds, clk_i, rst_ni, out_stall, out_plain_i, "result changed")
  `CKDM_ASSERT(a_result_follows, clk_i, rst_ni, in_xfer |-> ##2 out_valid_i, "result missing")
  `CKDM_ASSERT(a_ready_only_on_stall, clk_i, rst_ni, !in_ready_i |-> out_stall, "input stalled")

endmodule

bind card_key_derivation_mixer_core ckdm_checker u_ckdm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (text_if.valid),
  .in_ready_i  (text_if.ready),
  .out_valid_i (key_if.valid),
  .out_ready_i (key_if.ready),
  .out_plain_i (key_if.key_plain_half)
);
